// ===== rtl/tgs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the timestamp gap segmenter.
// No dependencies; every other file in rtl/ imports this package.
package tgs_pkg;

	// Action codes of an input beat.
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_NEXT  = 2'd2;
	localparam logic [1:0] ACT_CHECK = 2'd3;

	// Verdict codes of an output beat.
	localparam logic [3:0] V_OK         = 4'd0;
	localparam logic [3:0] V_RESTART    = 4'd1;
	localparam logic [3:0] V_STALE      = 4'd2;
	localparam logic [3:0] V_FILLED     = 4'd3;
	localparam logic [3:0] V_SPLIT      = 4'd4;
	localparam logic [3:0] V_NO_SEGMENT = 4'd5;
	localparam logic [3:0] V_ODD_GAP    = 4'd6;
	localparam logic [3:0] V_FULL       = 4'd7;
	localparam logic [3:0] V_LOADED     = 4'd8;
	localparam logic [3:0] V_NONE_LEFT  = 4'd9;

	// Configuration register indexes.
	localparam logic [1:0] CFG_INIT_MODE = 2'd0;
	localparam logic [1:0] CFG_WRAP      = 2'd1;
	localparam logic [1:0] CFG_GAP_LIMIT = 2'd2;

	localparam logic [15:0] GAP_LIMIT_RESET = 16'd7200;
	localparam logic [31:0] MIDNIGHT_LAST   = 32'd86399;

	typedef struct packed {
		logic        init_mode;
		logic        wrap_at_midnight;
		logic [15:0] short_gap_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] time_stamp;
		logic [31:0] interval_begin;
		logic [31:0] interval_end;
		logic        end_open;
	} in_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic [31:0] fill_start;
		logic [15:0] fill_count;
		logic [31:0] seg_begin;
		logic [31:0] seg_end;
		logic        seg_open;
	} out_t;

	// One interval of the table.
	typedef struct packed {
		logic [31:0] seg_begin;
		logic [31:0] seg_end;
		logic        seg_open;
	} entry_t;

endpackage

// ===== rtl/tgs_table.sv =====
`timescale 1ns / 1ps
// Interval table: one write port and one read port with registered read data.
// Depends on tgs_pkg for the entry type.
module tgs_table #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  tgs_pkg::entry_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output tgs_pkg::entry_t          rdata
);
	import tgs_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tgs_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the segmenter: runs each action against the interval table,
// holds counters, last time and the output register. Depends on tgs_pkg, tgs_table.
module tgs_ctrl #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tgs_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  tgs_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tgs_pkg::out_t out_data
);
	import tgs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_EXEC     = 4'd1;
	localparam logic [3:0] ST_NEXT_RD  = 4'd2;
	localparam logic [3:0] ST_NEXT_DAT = 4'd3;
	localparam logic [3:0] ST_SRCH_RD  = 4'd4;
	localparam logic [3:0] ST_SRCH_EV  = 4'd5;
	localparam logic [3:0] ST_SHIFT_RD = 4'd6;
	localparam logic [3:0] ST_SHIFT_WR = 4'd7;
	localparam logic [3:0] ST_FIX_UP   = 4'd8;
	localparam logic [3:0] ST_FIX_LOW  = 4'd9;
	localparam logic [3:0] ST_DONE     = 4'd10;

	logic [3:0]    state_q;
	in_t           item_q;
	out_t          res_q;
	out_t          out_q;
	logic          out_valid_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cur_q;
	logic          started_q;
	logic          ltv_q;
	logic [31:0]   last_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	entry_t        ent_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        rd_data;

	logic          seq_ok;
	logic [31:0]   diff;
	logic [31:0]   diff_m1;
	logic          short_gap;
	logic          tbl_full;
	logic [CW-1:0] cnt_eff;
	logic [CW-1:0] nxt;
	logic [CW-1:0] i_inc;
	logic [CW-1:0] j_dec;
	logic          hit;
	logic          covers;

	// A result beat that carries only a verdict.
	function automatic out_t verdict_only(input logic [3:0] v);
		out_t r;
		r         = '0;
		r.verdict = v;
		return r;
	endfunction

	tgs_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	assign seq_ok = !ltv_q
		|| ({1'b0, last_q} + 33'd1 == {1'b0, item_q.time_stamp})
		|| (cfg.wrap_at_midnight && item_q.time_stamp == 32'd0 && last_q == MIDNIGHT_LAST);
	assign diff      = item_q.time_stamp - last_q;
	assign diff_m1   = diff - 32'd1;
	assign short_gap = diff < {16'd0, cfg.short_gap_limit};
	assign tbl_full  = cnt_q >= CW'(TABLE_DEPTH);
	assign cnt_eff   = (cnt_q == '0) ? CW'(1) : cnt_q;
	assign nxt       = started_q ? cur_q + CW'(1) : '0;
	assign i_inc     = i_q + CW'(1);
	assign j_dec     = j_q - CW'(1);
	// The active interval holds the last time, or it runs open to the end of data.
	assign hit    = (last_q > rd_data.seg_begin && last_q <= rd_data.seg_end) || rd_data.seg_open;
	assign covers = item_q.time_stamp <= rd_data.seg_end || rd_data.seg_open;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = '{seg_begin: item_q.interval_begin, seg_end: item_q.interval_end,
			seg_open: item_q.end_open};
		mem_raddr = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (item_q.action == ACT_LOAD && !tbl_full) begin
					mem_we = 1'b1;
				end else if (item_q.action == ACT_NEXT && cnt_q == '0) begin
					// An empty table gets one open interval starting at zero.
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = '{seg_begin: 32'd0, seg_end: 32'd0, seg_open: 1'b1};
				end
			end
			ST_NEXT_RD: mem_raddr = cur_q[AW-1:0];
			ST_SRCH_RD: mem_raddr = i_q[AW-1:0];
			ST_SHIFT_RD: mem_raddr = j_dec[AW-1:0];
			ST_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = j_q[AW-1:0];
				mem_wdata = rd_data;
			end
			ST_FIX_UP: begin
				// Upper half of the split starts at the new stamp.
				mem_we    = 1'b1;
				mem_waddr = i_inc[AW-1:0];
				mem_wdata = '{seg_begin: item_q.time_stamp, seg_end: ent_q.seg_end,
					seg_open: ent_q.seg_open};
			end
			ST_FIX_LOW: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[AW-1:0];
				mem_wdata = '{seg_begin: ent_q.seg_begin, seg_end: last_q, seg_open: 1'b0};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			cur_q       <= '0;
			started_q   <= 1'b0;
			ltv_q       <= 1'b0;
			last_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			ent_q       <= '0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (item_q.action)
						ACT_CLEAR: begin
							cnt_q     <= '0;
							cur_q     <= '0;
							started_q <= 1'b0;
							ltv_q     <= 1'b0;
							res_q     <= verdict_only(V_OK);
							state_q   <= ST_DONE;
						end
						ACT_LOAD: begin
							if (tbl_full) begin
								res_q <= verdict_only(V_FULL);
							end else begin
								cnt_q <= cnt_q + CW'(1);
								res_q <= verdict_only(V_LOADED);
							end
							state_q <= ST_DONE;
						end
						ACT_NEXT: begin
							if (cnt_q == '0) begin
								cnt_q <= CW'(1);
							end
							if (nxt >= cnt_eff) begin
								res_q   <= verdict_only(V_NONE_LEFT);
								state_q <= ST_DONE;
							end else begin
								cur_q     <= nxt;
								started_q <= 1'b1;
								ltv_q     <= 1'b0;
								state_q   <= ST_NEXT_RD;
							end
						end
						ACT_CHECK: begin
							priority if (seq_ok) begin
								last_q  <= item_q.time_stamp;
								ltv_q   <= 1'b1;
								res_q   <= verdict_only(V_OK);
								state_q <= ST_DONE;
							end else if (cfg.init_mode) begin
								ltv_q   <= 1'b0;
								res_q   <= verdict_only(V_RESTART);
								state_q <= ST_DONE;
							end else if (last_q >= item_q.time_stamp) begin
								res_q   <= verdict_only(V_STALE);
								state_q <= ST_DONE;
							end else if (short_gap) begin
								last_q  <= item_q.time_stamp;
								res_q   <= '{verdict: V_FILLED, fill_start: last_q,
									fill_count: diff_m1[15:0], seg_begin: 32'd0,
									seg_end: 32'd0, seg_open: 1'b0};
								state_q <= ST_DONE;
							end else begin
								i_q     <= '0;
								state_q <= ST_SRCH_RD;
							end
						end
					endcase
				end
				ST_NEXT_RD: state_q <= ST_NEXT_DAT;
				ST_NEXT_DAT: begin
					res_q   <= '{verdict: V_OK, fill_start: 32'd0, fill_count: 16'd0,
						seg_begin: rd_data.seg_begin, seg_end: rd_data.seg_end,
						seg_open: rd_data.seg_open};
					state_q <= ST_DONE;
				end
				ST_SRCH_RD: begin
					if (i_q >= cnt_q) begin
						res_q   <= verdict_only(V_NO_SEGMENT);
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SRCH_EV;
					end
				end
				ST_SRCH_EV: begin
					if (!hit) begin
						i_q     <= i_inc;
						state_q <= ST_SRCH_RD;
					end else begin
						ent_q <= rd_data;
						if (!covers) begin
							last_q  <= item_q.time_stamp;
							res_q   <= verdict_only(V_ODD_GAP);
							state_q <= ST_DONE;
						end else if (tbl_full) begin
							res_q   <= verdict_only(V_FULL);
							state_q <= ST_DONE;
						end else begin
							j_q     <= cnt_q;
							state_q <= ST_SHIFT_RD;
						end
					end
				end
				ST_SHIFT_RD: begin
					// Entries above the hit move up by one, from the top down.
					if (j_q <= i_inc) begin
						state_q <= ST_FIX_UP;
					end else begin
						state_q <= ST_SHIFT_WR;
					end
				end
				ST_SHIFT_WR: begin
					j_q     <= j_dec;
					state_q <= ST_SHIFT_RD;
				end
				ST_FIX_UP: state_q <= ST_FIX_LOW;
				ST_FIX_LOW: begin
					cnt_q   <= cnt_q + CW'(1);
					res_q   <= verdict_only(V_SPLIT);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/timestamp_gap_segmenter_unit.sv =====
`timescale 1ns / 1ps
// Timestamp gap segmenter: keeps a table of time intervals and classifies
// record times against the last one. Depends on tgs_pkg, tgs_ctrl.
//
// Use: one input beat (in_valid/in_ready, in_data) carries an action: clear,
// load an interval, hand out the next interval, or check a time stamp. Each
// input beat gives exactly one output beat (out_valid/out_ready, out_data).
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle;
// the unit itself does not enforce this. Clear, load and quick checks pass
// through the execute and done states; next-interval adds a table read. A check
// that falls into a long gap reads and evaluates each table entry visited; a
// split then moves each entry above the hit with a read and a write and writes
// the two halves. One item is in work at a time: a new one is taken only when
// the previous has reached the output register.
// An output register holds a finished result; the next item is taken while
// it waits, but its own result waits until the receiver takes the previous.
// Reset empties the table, clears the handout pointer and the last time, and
// loads the registers with their defaults (gap limit 7200). Table storage is
// not cleared; only entries that were loaded are ever read.
module timestamp_gap_segmenter_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tgs_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output tgs_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	import tgs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_mode        <= 1'b0;
			cfg_q.wrap_at_midnight <= 1'b0;
			cfg_q.short_gap_limit  <= GAP_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INIT_MODE: cfg_q.init_mode        <= cfg_data[0];
				CFG_WRAP:      cfg_q.wrap_at_midnight <= cfg_data[0];
				CFG_GAP_LIMIT: cfg_q.short_gap_limit  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tgs_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
